// ===== hw/rtl/rlcs_pkg.sv =====
// Shared types and constants for the RGB LED chain serializer.
package rlcs_pkg;

  typedef logic [23:0] pixel_t;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] REG_LED_COUNT  = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd2;
  localparam logic [2:0] REG_BIT_TICKS  = 3'd3;
  localparam logic [2:0] REG_RESET_GAP  = 3'd4;

  localparam logic [9:0]  LED_COUNT_RST  = 10'd408;
  localparam logic [11:0] ONE_HIGH_RST   = 12'd20;
  localparam logic [11:0] ZERO_HIGH_RST  = 12'd10;
  localparam logic [11:0] BIT_TICKS_RST  = 12'd30;
  localparam logic [15:0] RESET_GAP_RST  = 16'd20000;

  typedef struct packed {
    logic [9:0]  led_count;
    logic [11:0] one_high_ticks;
    logic [11:0] zero_high_ticks;
    logic [11:0] bit_ticks;
    logic [15:0] reset_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic   en;
    logic [8:0] index;
    pixel_t data;
  } pix_wr_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } result_t;

  typedef struct packed {
    logic fetch;
    logic sending;
    logic in_gap;
  } status_t;

endpackage

// ===== hw/rtl/rlcs_cmd_if.sv =====
// Command channel interface carrying one input item per transfer.
interface rlcs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [8:0] led_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, command, led_index, red, green, blue, input ready);
  modport sink (input valid, command, led_index, red, green, blue, output ready);
endinterface

// ===== hw/rtl/rlcs_res_if.sv =====
// Result channel interface carrying one result item per transfer.
interface rlcs_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, line_level, busy_res, frame_done, input ready);
  modport sink (input valid, line_level, busy_res, frame_done, output ready);
endinterface

// ===== hw/rtl/rlcs_cfg_if.sv =====
// Configuration write channel interface.
interface rlcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rlcs_pixel_store.sv =====
// Pixel memory with a registered read port and same-cycle write forwarding.
module rlcs_pixel_store #(
  parameter int MAX_LEDS = 512,
  parameter int LW = $clog2(MAX_LEDS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  rlcs_pkg::pix_wr_t wr,
  input  logic [LW-1:0]    raddr,
  output rlcs_pkg::pixel_t rd_pixel,
  output logic [LW-1:0]    rd_idx
);
  import rlcs_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  pixel_t        mem [MAX_LEDS];
  pixel_t        rdata;
  pixel_t        fwd_data;
  logic          fwd_valid;
  logic          wr_ok;
  logic [AW-1:0] waddr;

  assign wr_ok = wr.en && (32'(wr.index) < 32'(MAX_LEDS));
  assign waddr = AW'(wr.index);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[waddr] <= wr.data;
    end
    rdata    <= mem[AW'(raddr)];
    rd_idx   <= raddr;
    fwd_data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_ok && (32'(wr.index) == 32'(raddr));
    end
  end

  assign rd_pixel = fwd_valid ? fwd_data : rdata;
endmodule

// ===== hw/rtl/rlcs_core.sv =====
// Frame sequencer: command decode, bit timing and line level per item.
module rlcs_core #(
  parameter int MAX_LEDS = 512,
  parameter int LW = $clog2(MAX_LEDS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         command,
  input  logic [8:0]         led_index,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  input  rlcs_pkg::cfg_t     cfg,
  input  rlcs_pkg::pixel_t   fetch_pixel,
  output rlcs_pkg::pix_wr_t  wr,
  output logic [LW-1:0]      raddr,
  output rlcs_pkg::result_t  result,
  output rlcs_pkg::status_t  status
);
  import rlcs_pkg::*;

  localparam int CW = (LW > 10) ? LW : 10;

  logic          sending, sending_next;
  logic          in_gap, in_gap_next;
  logic          line_hold, line_hold_next;
  logic [LW-1:0] led_counter, led_counter_next;
  logic [4:0]    bit_counter, bit_counter_next;
  logic [15:0]   tick_counter, tick_counter_next;
  pixel_t        current_pixel, current_pixel_next;

  logic [CW-1:0] lc_ext;
  logic [CW-1:0] frame_len;
  logic [11:0]   period;
  logic [15:0]   gap;
  logic [4:0]    bsel;
  logic          cur_bit;
  logic [11:0]   high;
  logic [15:0]   tick_inc;
  logic [4:0]    bit_inc;
  logic [LW-1:0] led_inc;
  logic          done;
  logic          fetch;

  assign lc_ext    = CW'(cfg.led_count);
  assign frame_len = (lc_ext > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : lc_ext;
  assign period    = (cfg.bit_ticks == 12'd0) ? 12'd1 : cfg.bit_ticks;
  assign gap       = (cfg.reset_gap_ticks == 16'd0) ? 16'd1 : cfg.reset_gap_ticks;
  assign bsel      = 5'd23 - bit_counter;
  assign cur_bit   = current_pixel[bsel];
  assign high      = cur_bit ? cfg.one_high_ticks : cfg.zero_high_ticks;
  assign tick_inc  = tick_counter + 16'd1;
  assign bit_inc   = bit_counter + 5'd1;
  assign led_inc   = led_counter + LW'(1);

  assign raddr = sending ? led_inc : '0;

  assign wr.en    = accept && (command == CMD_WRITE);
  assign wr.index = led_index;
  assign wr.data  = {red, green, blue};

  always_comb begin
    sending_next       = sending;
    in_gap_next        = in_gap;
    line_hold_next     = line_hold;
    led_counter_next   = led_counter;
    bit_counter_next   = bit_counter;
    tick_counter_next  = tick_counter;
    current_pixel_next = current_pixel;
    done               = 1'b0;
    fetch              = 1'b0;
    if (accept) begin
      case (command)
        CMD_START: begin
          if (!sending && !in_gap) begin
            led_counter_next  = '0;
            bit_counter_next  = '0;
            tick_counter_next = '0;
            if (frame_len == '0) begin
              in_gap_next = 1'b1;
            end else begin
              sending_next       = 1'b1;
              current_pixel_next = fetch_pixel;
              fetch              = 1'b1;
            end
          end
        end
        CMD_TICK: begin
          if (sending) begin
            line_hold_next    = tick_counter < 16'(high);
            tick_counter_next = tick_inc;
            if (tick_inc >= 16'(period)) begin
              tick_counter_next = '0;
              bit_counter_next  = bit_inc;
              if (bit_inc >= 5'd24) begin
                bit_counter_next = '0;
                led_counter_next = led_inc;
                if (CW'(led_inc) >= frame_len) begin
                  led_counter_next = '0;
                  sending_next     = 1'b0;
                  in_gap_next      = 1'b1;
                end else begin
                  current_pixel_next = fetch_pixel;
                  fetch              = 1'b1;
                end
              end
            end
          end else if (in_gap) begin
            line_hold_next    = 1'b0;
            tick_counter_next = tick_inc;
            if (tick_inc >= gap || tick_inc == 16'd0) begin
              tick_counter_next = '0;
              in_gap_next       = 1'b0;
              done              = 1'b1;
            end
          end else begin
            line_hold_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending       <= 1'b0;
      in_gap        <= 1'b0;
      line_hold     <= 1'b0;
      led_counter   <= '0;
      bit_counter   <= '0;
      tick_counter  <= '0;
      current_pixel <= '0;
    end else begin
      sending       <= sending_next;
      in_gap        <= in_gap_next;
      line_hold     <= line_hold_next;
      led_counter   <= led_counter_next;
      bit_counter   <= bit_counter_next;
      tick_counter  <= tick_counter_next;
      current_pixel <= current_pixel_next;
    end
  end

  assign result.line_level = line_hold_next;
  assign result.busy_res   = sending_next || in_gap_next;
  assign result.frame_done = done;

  assign status.fetch   = fetch;
  assign status.sending = sending;
  assign status.in_gap  = in_gap;
endmodule

// ===== hw/rtl/rlcs_out_fifo.sv =====
// Two-entry result queue that decouples the result channel from the core.
module rlcs_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rlcs_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  output rlcs_pkg::result_t out_data,
  input  logic              out_ready
);
  import rlcs_pkg::*;

  result_t    slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign room      = count < 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hw/rtl/rgb_led_chain_serializer_top.sv =====
// Top level of the RGB LED chain serializer with configuration registers.
// The result of an item is registered in the result queue before it is offered.
// Throughput: one item per cycle while the result queue has room; the result queue holds two results.
// The next pixel is read from the store ahead of its use by the registered read port.
// Reset: sequencer idle, line low, registers at defaults; pixel store is not cleared.
// After reset is released, input transfers wait until the warm register has been set.
module rgb_led_chain_serializer_top #(
  parameter int MAX_LEDS = 512
) (
  input  logic       clk,
  input  logic       rst,
  rlcs_cmd_if.sink   cmd,
  rlcs_res_if.source res,
  rlcs_cfg_if.sink   cfg
);
  import rlcs_pkg::*;

  localparam int LW = $clog2(MAX_LEDS + 1);

  cfg_t          regs;
  logic          warm;
  logic          room;
  logic          accept;
  pix_wr_t       wr;
  logic [LW-1:0] raddr;
  logic [LW-1:0] rd_idx;
  pixel_t        rd_pixel;
  result_t       result;
  result_t       out_data;
  status_t       status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.led_count       <= LED_COUNT_RST;
      regs.one_high_ticks  <= ONE_HIGH_RST;
      regs.zero_high_ticks <= ZERO_HIGH_RST;
      regs.bit_ticks       <= BIT_TICKS_RST;
      regs.reset_gap_ticks <= RESET_GAP_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_LED_COUNT: regs.led_count       <= cfg.data[9:0];
        REG_ONE_HIGH:  regs.one_high_ticks  <= cfg.data[11:0];
        REG_ZERO_HIGH: regs.zero_high_ticks <= cfg.data[11:0];
        REG_BIT_TICKS: regs.bit_ticks       <= cfg.data[11:0];
        REG_RESET_GAP: regs.reset_gap_ticks <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warm <= 1'b0;
    end else begin
      warm <= 1'b1;
    end
  end

  assign cmd.ready = warm && room;
  assign accept    = cmd.valid && cmd.ready;

  rlcs_pixel_store #(
    .MAX_LEDS (MAX_LEDS),
    .LW       (LW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .raddr    (raddr),
    .rd_pixel (rd_pixel),
    .rd_idx   (rd_idx)
  );

  rlcs_core #(
    .MAX_LEDS (MAX_LEDS),
    .LW       (LW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .command     (cmd.command),
    .led_index   (cmd.led_index),
    .red         (cmd.red),
    .green       (cmd.green),
    .blue        (cmd.blue),
    .cfg         (regs),
    .fetch_pixel (rd_pixel),
    .wr          (wr),
    .raddr       (raddr),
    .result      (result),
    .status      (status)
  );

  rlcs_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .room      (room),
    .out_valid (res.valid),
    .out_data  (out_data),
    .out_ready (res.ready)
  );

  assign res.line_level = out_data.line_level;
  assign res.busy_res   = out_data.busy_res;
  assign res.frame_done = out_data.frame_done;

  // A pixel fetch must see read data for the index the sequencer asks for.
  a_fetch_coherent: assert property (@(posedge clk) disable iff (rst)
    status.fetch |-> (rd_idx == raddr))
    else $error("pixel fetch used stale read data");

  a_state_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.sending && status.in_gap))
    else $error("sending and reset gap both active");

  a_done_from_gap: assert property (@(posedge clk) disable iff (rst)
    (accept && result.frame_done) |-> status.in_gap)
    else $error("frame done outside the reset gap");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result offered right after reset");
endmodule
